### rtl/core/crcgc_pkg.sv
// Shared types, constants and the byte-wide division step of the CRC generator/checker.
// Used by every module of the block; depends on nothing.
package crcgc_pkg;

  localparam int unsigned POLY_W         = 63;
  localparam int unsigned MAX_DEGREE_DEF = 63;
  localparam logic [POLY_W-1:0] POLY_RESET = 63'd263;
  localparam int unsigned REM_W          = 64;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned KEY_CNT_W      = 3;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_KEY     = 2'd0,
    ST_PASS    = 2'd1,
    ST_FAIL    = 2'd2,
    ST_BADPOLY = 2'd3
  } status_e;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Divider settings derived from the polynomial and mode registers at write time.
  typedef struct packed {
    logic [REM_W-1:0]     gen;
    logic [REM_W-1:0]     top_mask;
    logic [KEY_CNT_W-1:0] nkey;
    logic                 bad_poly;
    logic                 check_mode;
  } div_cfg_t;

  // Shifts one byte into the remainder, most significant bit first.
  function automatic logic [REM_W-1:0] div_byte(input logic [REM_W-1:0]  rem,
                                                input logic [BYTE_W-1:0] data,
                                                input logic [REM_W-1:0]  gen,
                                                input logic [REM_W-1:0]  top_mask);
    logic [REM_W-1:0] r;
    r = rem;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      r = {r[REM_W-2:0], data[b]};
      if (|(r & top_mask)) begin
        r = r ^ gen;
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/crcgc_front.sv
// Input side: accepts message words, tags them as data or end of message and queues them.
// Depends on crcgc_pkg.
module crcgc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [crcgc_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,
  output logic                          head_valid_o,
  output crcgc_pkg::cmd_t               head_o,
  input  logic                          pop_i
);
  import crcgc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;
  cmd_t            cmd_in;

  assign s_axis_tready = (cnt_q != CntW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid_o  = (cnt_q != '0);
  assign pop           = pop_i && head_valid_o;
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    cmd_in.kind = s_axis_tlast ? CMD_END : CMD_DATA;
    cmd_in.data = s_axis_tdata;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/core/crcgc_back.sv
// Division engine: divides queued words, augments and emits key words or a status verdict.
// Depends on crcgc_pkg; fed by crcgc_front.
module crcgc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crcgc_pkg::div_cfg_t           cfg_i,
  input  logic                          head_valid_i,
  input  crcgc_pkg::cmd_t               head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [crcgc_pkg::BYTE_W-1:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_axis_tuser,   // [1:0] status
  output logic                          m_axis_tlast
);
  import crcgc_pkg::*;

  typedef enum logic [2:0] {
    S_RUN = 3'b001,
    S_AUG = 3'b010,
    S_KEY = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [KEY_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_CNT_W-1:0] k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_byte_q;
  status_e              out_status_q;
  logic                 out_last_q;

  logic                 out_free;
  logic                 load;
  logic [BYTE_W-1:0]    load_byte;
  status_e              load_status;
  logic                 load_last;
  logic [BYTE_W-1:0]    div_in;
  logic [REM_W-1:0]     div_res;

  assign out_free = !out_valid_q || m_axis_tready;
  assign div_in   = (state_q == S_AUG) ? '0 : head_i.data;
  assign div_res  = div_byte(rem_q, div_in, cfg_i.gen, cfg_i.top_mask);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    load_byte   = '0;
    load_status = ST_KEY;
    load_last   = 1'b0;
    case (state_q)
      S_RUN: begin
        if (head_valid_i && (head_i.kind == CMD_DATA || out_free)) begin
          pop_o = 1'b1;
          rem_d = div_res;
          cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + KEY_CNT_W'(1);
          if (head_i.kind == CMD_END) begin
            if (cfg_i.bad_poly) begin
              load        = 1'b1;
              load_status = ST_BADPOLY;
              load_last   = 1'b1;
              rem_d       = '0;
              cnt_d       = '0;
            end else if (cfg_i.check_mode) begin
              // A message no longer than the key fails whatever the remainder is.
              load        = 1'b1;
              load_status = ((cnt_q >= cfg_i.nkey) && (div_res == '0)) ? ST_PASS : ST_FAIL;
              load_last   = 1'b1;
              rem_d       = '0;
              cnt_d       = '0;
            end else begin
              state_d = S_AUG;
              k_d     = cfg_i.nkey - KEY_CNT_W'(1);
            end
          end
        end
      end
      S_AUG: begin
        rem_d = div_res;
        if (k_q == '0) begin
          state_d = S_KEY;
          k_d     = cfg_i.nkey - KEY_CNT_W'(1);
        end else begin
          k_d = k_q - KEY_CNT_W'(1);
        end
      end
      S_KEY: begin
        if (out_free) begin
          load        = 1'b1;
          load_byte   = rem_q[{k_q, 3'b000} +: BYTE_W];
          load_status = ST_KEY;
          load_last   = (k_q == '0);
          if (k_q == '0) begin
            state_d = S_RUN;
            rem_d   = '0;
            cnt_d   = '0;
          end else begin
            k_d = k_q - KEY_CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      rem_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= load_byte;
      out_status_q <= load_status;
      out_last_q   <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("word taken from an empty queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !load)
    else $error("stalled result overwritten");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> !pop_o)
    else $error("word taken while finishing a message");

  a_rem_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KEY && state_d == S_RUN) |=> (rem_q == '0 && cnt_q == '0))
    else $error("remainder not cleared after last key word");
`endif

endmodule

### rtl/core/crc_generate_check_configurable_top.sv
// Top level of the configurable CRC generator/checker: configuration registers and wiring.
// Depends on crcgc_pkg, crcgc_front and crcgc_back.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata = data_byte, tlast = last
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata = out_byte, tuser = status,
//                                               tlast = out_last
//   cfg       in   cfg_we_i (no back-pressure)  cfg_idx_i, cfg_data_i
//
// The divider shifts a whole byte per cycle unless it waits on the output register.
// The last word of a generate message is divided in, then one augmenting zero byte per
// key word is shifted in, then the key words are emitted; no word is taken meanwhile.
// A two-word queue lets input be taken while the divider waits on the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
module crc_generate_check_configurable_top #(
  parameter int unsigned MaxDegree = crcgc_pkg::MAX_DEGREE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crcgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crcgc_pkg::POLY_W-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [crcgc_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [crcgc_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                       m_axis_tuser,   // [1:0] status
  output logic                             m_axis_tlast
);
  import crcgc_pkg::*;

  localparam int unsigned DegW = $clog2(MaxDegree + 1);

  div_cfg_t cfg_q, cfg_d;
  logic     head_valid;
  cmd_t     head;
  logic     pop;

  // The degree search runs once per polynomial register write, not per word.
  function automatic div_cfg_t derive(input logic [MaxDegree-1:0] p, input logic mode);
    div_cfg_t         c;
    logic [DegW-1:0]  deg;
    logic [REM_W-1:0] lead;
    deg = '0;
    for (int i = 0; i < MaxDegree; i++) begin
      if (p[i]) begin
        deg = DegW'(i + 1);
      end
    end
    lead         = REM_W'(1) << deg;
    c.gen        = REM_W'(p) | lead;
    c.top_mask   = ~(lead - REM_W'(1));
    c.nkey       = KEY_CNT_W'(deg >> 3);
    c.bad_poly   = (deg < DegW'(BYTE_W));
    c.check_mode = mode;
    return c;
  endfunction

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLY: cfg_d = derive(cfg_data_i[MaxDegree-1:0], cfg_q.check_mode);
        REG_MODE: cfg_d.check_mode = cfg_data_i[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= derive(POLY_RESET[MaxDegree-1:0], 1'b0);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  crcgc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  crcgc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/sv/crcgc_checker.sv
// Scoreboard for the configurable CRC generator/checker: watches config, input and output words,
// predicts every result word from its own copy of the divider state and compares field by field.
// Depends on crcgc_pkg for widths, register indexes and status codes.
`timescale 1ns / 100ps

module crcgc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crcgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [crcgc_pkg::POLY_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [crcgc_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [crcgc_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
  input  logic [1:0]                      m_axis_tuser,   // [1:0] status
  input  logic                            m_axis_tlast,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     due_cnt_o
);
  import crcgc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_e           status;
    logic              last;
  } crc_word_t;

  crc_word_t         words_due[$];
  logic [POLY_W-1:0] poly_cfg;
  logic              check_mode;
  logic [63:0]       crc_rem;
  logic [15:0]       msg_len;
  int unsigned       fail_cnt;

  function automatic int unsigned poly_degree(input logic [POLY_W-1:0] p);
    int unsigned n;
    n = 0;
    for (int i = 0; i < POLY_W; i++) begin
      if (p[i]) n = i + 1;
    end
    return n;
  endfunction

  // Shifts one byte in, most significant bit first; any bit at or above the degree
  // triggers a subtraction of the generator.
  function automatic logic [63:0] divide_byte(input logic [63:0]       rem,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [63:0]       gen,
                                              input int unsigned       deg);
    logic [63:0] r;
    r = rem;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      r = {r[62:0], b[i]};
      if ((r >> deg) != 64'd0) r = r ^ gen;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // Divides one accepted input word in and, on the last word of a message, queues
  // the result words it must produce.
  task automatic predict_crc_words(input logic [BYTE_W-1:0] b, input logic is_last);
    int unsigned deg;
    int unsigned key_len;
    logic [63:0] gen;
    crc_word_t   w;
    deg     = poly_degree(poly_cfg);
    gen     = {1'b0, poly_cfg} | (64'd1 << deg);
    key_len = deg / 8;
    crc_rem = divide_byte(crc_rem, b, gen, deg);
    if (msg_len != 16'hFFFF) msg_len++;
    if (is_last) begin
      if (deg < 8) begin
        w = '{data: '0, status: ST_BADPOLY, last: 1'b1};
        words_due = {words_due, w};
      end else if (!check_mode) begin
        for (int i = 0; i < key_len; i++) crc_rem = divide_byte(crc_rem, '0, gen, deg);
        for (int i = 0; i < key_len; i++) begin
          w.data   = BYTE_W'(crc_rem >> (8 * (key_len - 1 - i)));
          w.status = ST_KEY;
          w.last   = (i == key_len - 1);
          words_due = {words_due, w};
        end
      end else begin
        w.data   = '0;
        w.status = (msg_len > key_len && crc_rem == 64'd0) ? ST_PASS : ST_FAIL;
        w.last   = 1'b1;
        words_due = {words_due, w};
      end
      crc_rem = '0;
      msg_len = '0;
    end
  endtask

  task automatic compare_word(input logic [BYTE_W-1:0] d, input logic [1:0] s, input logic l);
    crc_word_t w;
    if (words_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word data %02h status %0d last %0b", d, s, l));
      return;
    end
    w = words_due.pop_front();
    if (d !== w.data)
      report_mismatch($sformatf("out_byte %02h, predicted %02h", d, w.data));
    if (s !== w.status)
      report_mismatch($sformatf("status %0d, predicted %0d", s, w.status));
    if (l !== w.last)
      report_mismatch($sformatf("out_last %0b, predicted %0b", l, w.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_cfg   = POLY_RESET;
      check_mode = 1'b0;
      crc_rem    = '0;
      msg_len    = '0;
      fail_cnt   = 0;
      words_due.delete();
      fail_cnt_o <= 0;
      due_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_POLY) poly_cfg = cfg_data_i;
        else if (cfg_idx_i == REG_MODE) check_mode = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) predict_crc_words(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) compare_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      fail_cnt_o <= fail_cnt;
      due_cnt_o  <= words_due.size();
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the configurable CRC generator/checker: clock, reset, configuration writes,
// directed and random messages with random stalls on both streams, and the final verdict.
// Depends on crcgc_pkg, crc_generate_check_configurable_top and crcgc_checker.
`timescale 1ns / 100ps

module tb;
  import crcgc_pkg::*;

  typedef logic [BYTE_W-1:0] octet_t;

  localparam int unsigned    DRAIN_CYCLES  = 32;
  localparam int unsigned    STALL_LIMIT   = 4000;
  localparam int unsigned    RANDOM_WORDS  = 84;
  localparam logic [POLY_W-1:0] POLY_MAX   = '1;
  localparam logic [POLY_W-1:0] MODE_GENERATE = 63'd0;
  localparam logic [POLY_W-1:0] MODE_CHECK    = 63'd1;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_POLY;
  logic [POLY_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  octet_t               s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  octet_t               m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned fail_cnt;
  int unsigned due_cnt;
  int unsigned words_sent = 0;
  octet_t      msg_q[$];

  crc_generate_check_configurable_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  crcgc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .due_cnt_o     (due_cnt)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // Sends the queued bytes as one run of words; tlast goes on the final one when asked.
  // Valid stays high from one word to the next unless a gap is drawn.
  task automatic send_msg(input bit with_last);
    foreach (msg_q[i]) begin
      while ($urandom_range(99) < snd_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= msg_q[i];
      s_axis_tlast  <= with_last && (i == msg_q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      words_sent++;
    end
    msg_q.delete();
  endtask

  // Waits until every predicted word has come out, then lets buffered data words drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POLY_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Appends the key that generate mode would produce for the queued bytes, so that
  // a check-mode run of the same bytes leaves a zero remainder.
  task automatic append_key(input logic [POLY_W-1:0] p);
    int unsigned deg;
    int unsigned nkey;
    logic [63:0] gen;
    logic [63:0] rem;
    octet_t      b;
    deg = 0;
    for (int i = 0; i < POLY_W; i++) begin
      if (p[i]) deg = i + 1;
    end
    gen  = {1'b0, p} | (64'd1 << deg);
    nkey = deg / 8;
    rem  = '0;
    for (int k = 0; k < msg_q.size() + nkey; k++) begin
      b = (k < msg_q.size()) ? msg_q[k] : 8'h00;
      for (int j = 7; j >= 0; j--) begin
        rem = {rem[62:0], b[j]};
        if ((rem >> deg) != 64'd0) rem = rem ^ gen;
      end
    end
    for (int i = nkey; i > 0; i--) msg_q = {msg_q, octet_t'(rem >> (8 * (i - 1)))};
  endtask

  // Mostly generators whose degree is a whole number of bytes, since only those give
  // keys that can make a check pass; a few are too short to be valid.
  function automatic logic [POLY_W-1:0] pick_poly();
    int unsigned deg;
    int unsigned pick;
    logic [63:0] r;
    pick = $urandom_range(9);
    if (pick == 0) return POLY_W'($urandom_range(127));
    if (pick < 6) deg = 8 * $urandom_range(1, 7);
    else deg = $urandom_range(8, 63);
    r = {$urandom, $urandom};
    r = (r & ((64'd1 << (deg - 1)) - 64'd1)) | (64'd1 << (deg - 1));
    return r[POLY_W-1:0];
  endfunction

  task automatic random_block(input int unsigned n_msgs);
    logic [POLY_W-1:0] p;
    logic [POLY_W-1:0] mode_val;
    int unsigned       len;
    p        = pick_poly();
    mode_val = POLY_W'({$urandom, $urandom});
    mode_val[0] = $urandom_range(1);
    write_reg(REG_POLY, p);
    write_reg(REG_MODE, mode_val);
    repeat (n_msgs) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      repeat (len) msg_q = {msg_q, octet_t'($urandom)};
      if (mode_val[0] && $urandom_range(3) != 0) append_key(p);
      send_msg(1'b1);
    end
    settle();
  endtask

  initial begin : stimulus
    int unsigned base;
    snd_idle <= 27;
    rcv_idle <= 86;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset generator, degree 9.
    msg_q = '{8'h31, 8'h32, 8'h33};
    send_msg(1'b1);
    msg_q = '{8'hFF};
    send_msg(1'b1);
    msg_q = '{8'h00};
    send_msg(1'b1);
    settle();

    // Generators shorter than eight bits, zero among them.
    write_reg(REG_POLY, 63'd0);
    msg_q = '{8'hA5};
    send_msg(1'b1);
    settle();
    write_reg(REG_POLY, 63'd127);
    msg_q = '{8'h5A, 8'h01};
    send_msg(1'b1);
    settle();

    // Shortest and longest valid generators.
    write_reg(REG_POLY, 63'd128);
    msg_q = '{8'h80};
    send_msg(1'b1);
    settle();
    write_reg(REG_POLY, POLY_MAX);
    msg_q = '{8'hFF, 8'h00, 8'h80};
    send_msg(1'b1);
    settle();

    // Check mode: a message no longer than the key fails even with a zero remainder.
    write_reg(REG_MODE, MODE_CHECK);
    write_reg(REG_POLY, 63'd128);
    msg_q = '{8'h00};
    send_msg(1'b1);
    msg_q = '{8'h00, 8'h00};
    send_msg(1'b1);
    msg_q = '{8'h12};
    append_key(63'd128);
    send_msg(1'b1);
    settle();

    // Generator and mode changed in the middle of a message.
    write_reg(REG_MODE, MODE_GENERATE);
    write_reg(REG_POLY, 63'h107);
    msg_q = '{8'h12, 8'h34};
    send_msg(1'b0);
    settle();
    write_reg(REG_POLY, 63'h8005);
    msg_q = '{8'h56};
    send_msg(1'b1);
    settle();
    write_reg(REG_POLY, POLY_MAX);
    msg_q = '{8'hFF, 8'hFF, 8'hFF};
    send_msg(1'b0);
    settle();
    write_reg(REG_POLY, 63'h107);
    write_reg(REG_MODE, MODE_CHECK);
    msg_q = '{8'hAB};
    send_msg(1'b1);
    settle();

    base = words_sent;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        snd_idle <= 86;
        rcv_idle <= 27;
      end else if (phase == 2) begin
        snd_idle <= 0;
        rcv_idle <= 0;
      end
      while (words_sent - base < (phase + 1) * RANDOM_WORDS / 3) begin
        random_block($urandom_range(2, 4));
      end
    end

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Ends the run if no word moves on either stream for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
